>>> rtl/hsdfm_pkg.sv
// Package for the high-side driver fault monitor.
// Holds channel count, codes, register indexes, reset values and shared types.
// No dependencies.
package hsdfm_pkg;

  localparam int unsigned NumChan = 4;
  localparam int unsigned ChanW   = 2;
  localparam int unsigned DataW   = 16;
  localparam int unsigned CfgIdxW = 3;

  // item commands
  localparam logic CmdMode = 1'b0;
  localparam logic CmdTick = 1'b1;

  // fault flag bit positions
  localparam int unsigned FlagStuck = 0;
  localparam int unsigned FlagOpen  = 1;
  localparam int unsigned FlagOvld  = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSettle  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInrush  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRetry   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStuckV  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOpenI   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOvldI   = 3'd5;

  localparam logic [DataW-1:0] RstSettle = 16'd10;
  localparam logic [DataW-1:0] RstInrush = 16'd10;
  localparam logic [DataW-1:0] RstRetry  = 16'd100;
  localparam logic [DataW-1:0] RstStuckV = 16'd1000;
  localparam logic [DataW-1:0] RstOpenI  = 16'd50;
  localparam logic [DataW-1:0] RstOvldI  = 16'd5000;

  typedef enum logic [3:0] {
    PhStart = 4'b0001,
    PhDelay = 4'b0010,
    PhMon   = 4'b0100,
    PhRetry = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [DataW-1:0] settle_delay;
    logic [DataW-1:0] inrush_delay;
    logic [DataW-1:0] retry_interval;
    logic [DataW-1:0] stuck_voltage;
    logic [DataW-1:0] open_current;
    logic [DataW-1:0] overload_current;
  } cfg_t;

  typedef struct packed {
    logic             mode;
    phase_e           phase;
    logic [DataW-1:0] count;
    logic [2:0]       flags;
  } chan_t;

  typedef struct packed {
    logic we;
    logic val;
  } pin_upd_t;

  localparam chan_t ChanRst = '{mode: 1'b0, phase: PhStart, count: '0, flags: '0};

endpackage

>>> rtl/hsdfm_cfg_regs.sv
// Configuration register file of the fault monitor: six 16-bit thresholds and delays.
// Depends on hsdfm_pkg.
module hsdfm_cfg_regs
  import hsdfm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSettle: cfg_d.settle_delay     = cfg_data_i;
        RegInrush: cfg_d.inrush_delay     = cfg_data_i;
        RegRetry:  cfg_d.retry_interval   = cfg_data_i;
        RegStuckV: cfg_d.stuck_voltage    = cfg_data_i;
        RegOpenI:  cfg_d.open_current     = cfg_data_i;
        RegOvldI:  cfg_d.overload_current = cfg_data_i;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_delay     <= RstSettle;
      cfg_q.inrush_delay     <= RstInrush;
      cfg_q.retry_interval   <= RstRetry;
      cfg_q.stuck_voltage    <= RstStuckV;
      cfg_q.open_current     <= RstOpenI;
      cfg_q.overload_current <= RstOvldI;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/hsdfm_chan_step.sv
// Next-state logic for one channel: mode request handling and the tick sequencer.
// Depends on hsdfm_pkg.
module hsdfm_chan_step
  import hsdfm_pkg::*;
(
  input  cfg_t             cfg_i,
  input  chan_t            cur_i,
  input  logic             cmd_i,
  input  logic             request_on_i,
  input  logic [DataW-1:0] volt_sample_i,
  input  logic [DataW-1:0] amp_sample_i,
  output chan_t            nxt_o,
  output pin_upd_t         pin_o
);

  logic ovld;

  assign ovld = amp_sample_i >= cfg_i.overload_current;

  always_comb begin
    nxt_o     = cur_i;
    pin_o.we  = 1'b0;
    pin_o.val = 1'b0;
    if (cmd_i == CmdTick) begin
      case (cur_i.phase)
        PhStart: begin
          pin_o.we  = 1'b1;
          pin_o.val = cur_i.mode;
          if (cur_i.mode) begin
            nxt_o.flags[FlagStuck] = 1'b0;
            nxt_o.count            = cfg_i.inrush_delay;
          end else begin
            nxt_o.flags[FlagOpen] = 1'b0;
            nxt_o.count           = cfg_i.settle_delay;
          end
          nxt_o.phase = PhDelay;
        end
        PhDelay, PhRetry: begin
          if (cur_i.count <= 16'd1) begin
            nxt_o.count = '0;
            nxt_o.phase = PhMon;
            // leaving retry redrives the pin
            if (cur_i.phase == PhRetry) begin
              pin_o.we  = 1'b1;
              pin_o.val = 1'b1;
            end
          end else begin
            nxt_o.count = cur_i.count - 16'd1;
          end
        end
        PhMon: begin
          nxt_o.flags[FlagOvld] = ovld;
          if (!cur_i.mode) begin
            nxt_o.flags[FlagStuck] = volt_sample_i >= cfg_i.stuck_voltage;
          end else begin
            nxt_o.flags[FlagOpen] = amp_sample_i <= cfg_i.open_current;
            if (ovld) begin
              pin_o.we    = 1'b1;
              pin_o.val   = 1'b0;
              nxt_o.count = cfg_i.retry_interval;
              nxt_o.phase = PhRetry;
            end
          end
        end
        default: ;
      endcase
    end else if (cur_i.mode != request_on_i) begin
      nxt_o.mode  = request_on_i;
      nxt_o.phase = PhStart;
      nxt_o.count = '0;
    end
  end

endmodule

>>> rtl/high_side_driver_fault_monitor.sv
// Top level of the high-side driver fault monitor: input word register, per-channel
// state, result register. Depends on hsdfm_pkg, hsdfm_cfg_regs, hsdfm_chan_step.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word: cmd_i selects a mode
//   request (request_on_i) or a sample tick (volt_sample_i, amp_sample_i) for
//   channel_i. Every word produces exactly one result word on the output channel
//   (out_valid_o/out_ready_i): the channel, all pin levels and that channel's
//   stuck, open and overload faults after the update.
//   Config channel (cfg_valid_i/cfg_ready_o) writes one register per word and is always
//   ready; it must be written only while the block is idle, which it does not enforce.
//   Path: the accept edge loads the input register; the sequencer output is loaded
//   into the result register once that register is empty or its result is taken.
//   Throughput: 1 word per cycle while results are taken, set by the single state
//   read-modify-write per cycle on the channel state registers.
//   Reset: all channels off and start pending, counters and faults clear, pins
//   low, registers at their default values.
//   Output stall: the result register holds; the input register still takes one
//   more word, then in_ready_o drops until the result is taken.
module high_side_driver_fault_monitor
  import hsdfm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [ChanW-1:0]   channel_i,
  input  logic               request_on_i,
  input  logic [DataW-1:0]   volt_sample_i,
  input  logic [DataW-1:0]   amp_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ChanW-1:0]   out_channel_o,
  output logic [NumChan-1:0] pin_state_o,
  output logic               stuck_fault_o,
  output logic               open_fault_o,
  output logic               overload_fault_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  cfg_t cfg;

  hsdfm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input word register
  logic             in_vld_q;
  logic             cmd_q;
  logic [ChanW-1:0] ch_q;
  logic             req_q;
  logic [DataW-1:0] volt_q;
  logic [DataW-1:0] amp_q;

  logic             adv;
  logic             out_vld_q;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_i;
      ch_q   <= channel_i;
      req_q  <= request_on_i;
      volt_q <= volt_sample_i;
      amp_q  <= amp_sample_i;
    end
  end

  // channel state
  chan_t              chan_q [NumChan];
  logic [NumChan-1:0] pin_drive_q, pin_drive_d;
  chan_t              cur, nxt;
  pin_upd_t           pin_upd;

  assign cur = chan_q[ch_q];

  hsdfm_chan_step u_step (
    .cfg_i         (cfg),
    .cur_i         (cur),
    .cmd_i         (cmd_q),
    .request_on_i  (req_q),
    .volt_sample_i (volt_q),
    .amp_sample_i  (amp_q),
    .nxt_o         (nxt),
    .pin_o         (pin_upd)
  );

  always_comb begin
    pin_drive_d = pin_drive_q;
    if (pin_upd.we) begin
      pin_drive_d[ch_q] = pin_upd.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChan; i++) begin
        chan_q[i] <= ChanRst;
      end
      pin_drive_q <= '0;
    end else if (adv) begin
      chan_q[ch_q] <= nxt;
      pin_drive_q  <= pin_drive_d;
    end
  end

  // result register
  logic [ChanW-1:0]   res_ch_q;
  logic [NumChan-1:0] res_pin_q;
  logic [2:0]         res_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_ch_q    <= ch_q;
      res_pin_q   <= pin_drive_d;
      res_flags_q <= nxt.flags;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_channel_o    = res_ch_q;
  assign pin_state_o      = res_pin_q;
  assign stuck_fault_o    = res_flags_q[FlagStuck];
  assign open_fault_o     = res_flags_q[FlagOpen];
  assign overload_fault_o = res_flags_q[FlagOvld];

  // checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled while pipeline not full");

  a_adv_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("processed word produced no result");

  for (genvar g = 0; g < NumChan; g++) begin : g_chk
    a_retry_pin_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (chan_q[g].phase == PhRetry) |-> (!pin_drive_q[g] && chan_q[g].mode))
      else $error("pin driven or channel off during overload retry");

    a_start_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (chan_q[g].phase == PhStart) |-> (chan_q[g].count == '0))
      else $error("delay count not cleared in start phase");
  end

endmodule
